// File: rtl/core/ngpcd_pkg.sv
// ----------------------------------------------------------------------------
// ngpcd_pkg: shared types for the NGP charge deposition block
// Opcodes, status codes, config register indexes, payload and control structs.
// ----------------------------------------------------------------------------
package ngpcd_pkg;

    // Config register indexes
    localparam logic [2:0] CFG_SCALE_X     = 3'd0;
    localparam logic [2:0] CFG_SCALE_Y     = 3'd1;
    localparam logic [2:0] CFG_FRAME_SHIFT = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_DEPOSIT = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } t_ngp_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OUTSIDE   = 2'd1,
        STS_SATURATED = 2'd2
    } t_ngp_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic [27:0]        position_x;
        logic [27:0]        position_y;
        logic signed [23:0] particle_weight;
        logic [11:0]        read_index;
    } t_ngp_in;

    typedef struct packed {
        logic signed [31:0] cell_value;
        logic [1:0]         status;
    } t_ngp_out;

    typedef struct packed {
        logic [23:0] scale_x;
        logic [23:0] scale_y;
        logic [15:0] frame_shift;
        logic [6:0]  grid_width;
        logic [6:0]  grid_height;
    } t_ngp_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MULX,
        ST_MULY,
        ST_LOCATE,
        ST_FETCH,
        ST_UPDATE,
        ST_REPORT
    } t_ngp_state;

    // What the result register captures
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_OUTSIDE,
        RES_SUM,
        RES_CELL
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      mul_x;
        logic      mul_y;
        logic      locate;
        logic      mem_rd;
        logic      acc_wr;
        logic      clr_wr;
        logic      emit;
        t_res_kind res_kind;
    } t_ngp_cmd;

    typedef struct packed {
        t_ngp_op op;
        logic    outside;
        logic    clr_last;
    } t_ngp_stat;

endpackage

// File: rtl/core/ngp_charge_deposit.sv
// ----------------------------------------------------------------------------
// ngp_charge_deposit: nearest-grid-point charge deposition
// Top level: config register file, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an operation transfers on a clock edge with start high
//   and busy low. Operations: clear grid, deposit particle, read cell.
//   Result channel: o_done pulses for one cycle with o_out valid; each
//   operation yields exactly one result. The receiver cannot stall, so
//   results are simply presented with the o_done pulse.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_wdata, written by the user only
//   while idle; the block itself does not enforce it. One operation runs
//   at a time. Deposit: two multiply steps on the shared multiplier,
//   locate, RAM read, update. Read: locate, RAM read, report. If outside,
//   both end at the RAM read step without reading. An unused opcode
//   answers at once; clear writes one word/cycle. The cell RAM's single
//   write port sets clear length; the controller steps set deposit/read rate.
// Reset: config returns to defaults, then a clearing pass zeroes all
//   MAX_CELLS_X*MAX_CELLS_Y cells of the RAM with busy high and no
//   result. Config writes are taken during that pass.
// ----------------------------------------------------------------------------
module ngp_charge_deposit #(
    parameter int MAX_CELLS_X = 64,
    parameter int MAX_CELLS_Y = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  ngpcd_pkg::t_ngp_in                  i_in,
    // result channel
    output logic                                o_done,
    output ngpcd_pkg::t_ngp_out                 o_out,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [ngpcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ngpcd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Config registers, reset to unity scale, no shift, full grid
    ngpcd_pkg::t_ngp_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_x     <= 24'd65536;
            r_cfg.scale_y     <= 24'd65536;
            r_cfg.frame_shift <= 16'd0;
            r_cfg.grid_width  <= 7'd64;
            r_cfg.grid_height <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ngpcd_pkg::CFG_SCALE_X:     r_cfg.scale_x     <= i_cfg_wdata;
                ngpcd_pkg::CFG_SCALE_Y:     r_cfg.scale_y     <= i_cfg_wdata;
                ngpcd_pkg::CFG_FRAME_SHIFT: r_cfg.frame_shift <= i_cfg_wdata[15:0];
                ngpcd_pkg::CFG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_wdata[6:0];
                ngpcd_pkg::CFG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_wdata[6:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    ngpcd_pkg::t_ngp_cmd  cmd;
    ngpcd_pkg::t_ngp_stat stat;

    ngpcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (ngpcd_pkg::t_ngp_op'(i_in.operation)),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    ngpcd_datapath #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule

// File: rtl/core/ngpcd_ctrl.sv
// ----------------------------------------------------------------------------
// ngpcd_ctrl: sequencing controller
// Walks each operation through the datapath steps and issues commands.
// ----------------------------------------------------------------------------
module ngpcd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  ngpcd_pkg::t_ngp_op   i_op,
    input  ngpcd_pkg::t_ngp_stat i_stat,
    output logic                 busy,
    output ngpcd_pkg::t_ngp_cmd  o_cmd
);

    ngpcd_pkg::t_ngp_state r_state, n_state;
    logic                  r_clr_report, n_clr_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ngpcd_pkg::ST_CLEAR;  // power-on sweep
            r_clr_report <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_report <= n_clr_report;
        end
    end

    assign busy = (r_state != ngpcd_pkg::ST_IDLE);

    // Next state
    always_comb begin
        n_state      = r_state;
        n_clr_report = r_clr_report;
        unique case (r_state)
            ngpcd_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_op)
                        ngpcd_pkg::OP_CLEAR: begin
                            n_state      = ngpcd_pkg::ST_CLEAR;
                            n_clr_report = 1'b1;
                        end
                        ngpcd_pkg::OP_DEPOSIT: n_state = ngpcd_pkg::ST_MULX;
                        ngpcd_pkg::OP_READ:    n_state = ngpcd_pkg::ST_LOCATE;
                        default:               n_state = ngpcd_pkg::ST_IDLE;
                    endcase
                end
            end
            ngpcd_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state      = ngpcd_pkg::ST_IDLE;
                    n_clr_report = 1'b0;
                end
            end
            ngpcd_pkg::ST_MULX:   n_state = ngpcd_pkg::ST_MULY;
            ngpcd_pkg::ST_MULY:   n_state = ngpcd_pkg::ST_LOCATE;
            ngpcd_pkg::ST_LOCATE: n_state = ngpcd_pkg::ST_FETCH;
            ngpcd_pkg::ST_FETCH: begin
                if (i_stat.outside) begin
                    n_state = ngpcd_pkg::ST_IDLE;
                end else if (i_stat.op == ngpcd_pkg::OP_DEPOSIT) begin
                    n_state = ngpcd_pkg::ST_UPDATE;
                end else begin
                    n_state = ngpcd_pkg::ST_REPORT;
                end
            end
            ngpcd_pkg::ST_UPDATE: n_state = ngpcd_pkg::ST_IDLE;
            ngpcd_pkg::ST_REPORT: n_state = ngpcd_pkg::ST_IDLE;
            default:              n_state = ngpcd_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = ngpcd_pkg::RES_ZERO;
        unique case (r_state)
            ngpcd_pkg::ST_IDLE: begin
                o_cmd.load = start;
                // unused opcode answers at once
                o_cmd.emit = start && (i_op == ngpcd_pkg::OP_NOP);
            end
            ngpcd_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.emit   = i_stat.clr_last && r_clr_report;
            end
            ngpcd_pkg::ST_MULX:   o_cmd.mul_x  = 1'b1;
            ngpcd_pkg::ST_MULY:   o_cmd.mul_y  = 1'b1;
            ngpcd_pkg::ST_LOCATE: o_cmd.locate = 1'b1;
            ngpcd_pkg::ST_FETCH: begin
                o_cmd.mem_rd   = !i_stat.outside;
                o_cmd.emit     = i_stat.outside;
                o_cmd.res_kind = ngpcd_pkg::RES_OUTSIDE;
            end
            ngpcd_pkg::ST_UPDATE: begin
                o_cmd.acc_wr   = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.res_kind = ngpcd_pkg::RES_SUM;
            end
            ngpcd_pkg::ST_REPORT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.res_kind = ngpcd_pkg::RES_CELL;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/ngpcd_datapath.sv
// ----------------------------------------------------------------------------
// ngpcd_datapath: operand registers, shared multiplier, cell store, result
// One multiplier serves both axes; the cell store is a single-port-write RAM.
// ----------------------------------------------------------------------------
module ngpcd_datapath #(
    parameter int MAX_CELLS_X = 64,
    parameter int MAX_CELLS_Y = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ngpcd_pkg::t_ngp_in   i_in,
    input  ngpcd_pkg::t_ngp_cfg  i_cfg,
    input  ngpcd_pkg::t_ngp_cmd  i_cmd,
    output ngpcd_pkg::t_ngp_stat o_stat,
    output logic                 o_done,
    output ngpcd_pkg::t_ngp_out  o_out
);

    localparam int CELLS = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int IDX_W = $clog2(CELLS);

    // Latched item
    ngpcd_pkg::t_ngp_op r_op;
    logic [27:0]        r_px, r_py;
    logic signed [23:0] r_wt;
    logic [11:0]        r_ridx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= ngpcd_pkg::t_ngp_op'(i_in.operation);
            r_px   <= i_in.position_x;
            r_py   <= i_in.position_y;
            r_wt   <= i_in.particle_weight;
            r_ridx <= i_in.read_index;
        end
    end

    // Shared 28x24 multiplier, integer cell = product >> 32
    logic [27:0] mul_a;
    logic [23:0] mul_b;
    logic [51:0] prod;
    logic [19:0] r_cx_raw, r_cy;

    assign mul_a = i_cmd.mul_y ? r_py : r_px;
    assign mul_b = i_cmd.mul_y ? i_cfg.scale_y : i_cfg.scale_x;
    assign prod  = 52'(mul_a) * 52'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_x) r_cx_raw <= prod[51:32];
        if (i_cmd.mul_y) r_cy     <= prod[51:32];
    end

    // Effective grid size
    logic [6:0]  eff_w, eff_h;
    logic [13:0] area;

    assign eff_w = (32'(i_cfg.grid_width) > MAX_CELLS_X) ? 7'(MAX_CELLS_X) : i_cfg.grid_width;
    assign eff_h = (32'(i_cfg.grid_height) > MAX_CELLS_Y) ? 7'(MAX_CELLS_Y)
                                                           : i_cfg.grid_height;
    assign area  = 14'(eff_w) * 14'(eff_h);

    // Locate: bounds check and linear index
    logic signed [20:0] cx_s;
    logic               dep_out, rd_out;
    logic [13:0]        dep_idx;
    logic [IDX_W-1:0]   r_addr;
    logic               r_outside;

    assign cx_s    = $signed({1'b0, r_cx_raw}) - $signed({5'b0, i_cfg.frame_shift});
    assign dep_out = cx_s[20] || (cx_s[19:0] >= {13'b0, eff_w}) || (r_cy >= {13'b0, eff_h});
    assign dep_idx = 14'(cx_s[6:0]) * 14'(eff_h) + 14'(r_cy[6:0]);
    assign rd_out  = !({2'b0, r_ridx} < area);

    always_ff @(posedge i_clk) begin
        if (i_cmd.locate) begin
            if (r_op == ngpcd_pkg::OP_DEPOSIT) begin
                r_outside <= dep_out;
                r_addr    <= IDX_W'(dep_idx);
            end else begin
                r_outside <= rd_out;
                r_addr    <= IDX_W'(r_ridx);
            end
        end
    end

    // Clear sweep counter
    logic [IDX_W-1:0] r_clr_cnt;
    logic             clr_last;

    assign clr_last = (r_clr_cnt == IDX_W'(CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= clr_last ? '0 : r_clr_cnt + 1'b1;
        end
    end

    // Saturating accumulate
    logic signed [31:0] r_rdata;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;
    logic               sat;

    assign sum     = 33'(r_rdata) + 33'(r_wt);
    assign sat     = (sum[32] != sum[31]);
    assign sum_sat = !sat    ? sum[31:0]
                   : sum[32] ? 32'sh8000_0000
                             : 32'sh7fff_ffff;

    // Cell store
    logic signed [31:0] mem [CELLS];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic signed [31:0] mem_wd;

    assign mem_we = i_cmd.clr_wr || i_cmd.acc_wr;
    assign mem_wa = i_cmd.clr_wr ? r_clr_cnt : r_addr;
    assign mem_wd = i_cmd.clr_wr ? 32'sd0 : sum_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (i_cmd.mem_rd) r_rdata <= mem[r_addr];
    end

    // Result register
    ngpcd_pkg::t_ngp_out r_out;
    logic                r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.res_kind)
                ngpcd_pkg::RES_OUTSIDE: begin
                    r_out.cell_value <= '0;
                    r_out.status     <= ngpcd_pkg::STS_OUTSIDE;
                end
                ngpcd_pkg::RES_SUM: begin
                    r_out.cell_value <= sum_sat;
                    r_out.status     <= sat ? ngpcd_pkg::STS_SATURATED : ngpcd_pkg::STS_OK;
                end
                ngpcd_pkg::RES_CELL: begin
                    r_out.cell_value <= r_rdata;
                    r_out.status     <= ngpcd_pkg::STS_OK;
                end
                default: begin
                    r_out.cell_value <= '0;
                    r_out.status     <= ngpcd_pkg::STS_OK;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_out           = r_out;
    assign o_stat.op       = r_op;
    assign o_stat.outside  = r_outside;
    assign o_stat.clr_last = clr_last;

endmodule
